// ----- src/pacpt_pkg.sv -----
package pacpt_pkg;

  localparam int COORD_W   = 16;
  localparam int MAX_VERTS = 64;
  localparam int ADDR_W    = $clog2(MAX_VERTS);
  localparam int CNT_W     = 7;
  localparam int TOTAL_W   = 7;
  localparam int AREA_W    = 36;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;

  // Edge arithmetic widths.
  localparam int PROD_W = 2 * COORD_W;
  localparam int CR_W   = PROD_W + 1;
  localparam int ACC_W  = CR_W + ADDR_W;
  localparam int SUM_W  = COORD_W + 1;
  localparam int MOM_W  = SUM_W + CR_W;
  localparam int AX_W   = MOM_W + ADDR_W;
  localparam int DEN_W  = ACC_W + 2;
  localparam int LT_W   = 2 * (COORD_W + 1);

  // Divider widths: QB quotient bits, one extra step detects overflow.
  localparam int QB     = COORD_W + 2;
  localparam int SH_W   = $clog2(QB + 1);
  localparam int DIV_W  = (AX_W + 2 > DEN_W + 1 + QB) ? AX_W + 2 : DEN_W + 1 + QB;

  // Cycles from the last store read until the moment sums are final.
  localparam int PIPE_LAT = 4;
  localparam int DRN_W    = $clog2(PIPE_LAT);

  localparam int IN_TDATA_W  = 2 * COORD_W;
  localparam int RES_BITS    = AREA_W + 2 * COORD_W + 1 + TOTAL_W;
  localparam int OUT_TDATA_W = ((RES_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_DEG  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_AREA,
    S_DIVX,
    S_DIVY,
    S_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_PREP,
    DV_RUN,
    DV_FIN
  } div_state_t;

  typedef struct packed {
    logic                load;
    logic                clr_poly;
    logic                walk_start;
    logic                rd_valid;
    logic                rd_first;
    logic                area_upd;
    logic                div_start;
    logic                div_sel;
    logic                res_load;
    logic [STAT_W-1:0]   res_status;
    logic                res_inside;
    logic [TOTAL_W-1:0]  res_total;
  } cmd_t;

  typedef struct packed {
    logic acc_zero;
    logic area_zero;
    logic div_done;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [TOTAL_W-1:0]        total;
    logic                      hit;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cx;
    logic [AREA_W-1:0]         area;
  } res_t;

endpackage

// ----- src/pacpt_ram.sv -----
module pacpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/pacpt_div.sv -----
module pacpt_div import pacpt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic signed [AX_W-1:0]    num_i,
  input  logic signed [DEN_W-1:0]   den_i,
  output logic                      done_o,
  output logic signed [COORD_W-1:0] quo_o
);

  // Rounded quotient is floor((2|n| + |d|) / (2|d|)), one bit per cycle.
  div_state_t        state_r, state_nxt;
  logic [AX_W-1:0]   nm_r;
  logic [DEN_W-1:0]  dm_r;
  logic              neg_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  ds_r;
  logic [QB-1:0]     q_r;
  logic [SH_W-1:0]   sh_r;
  logic              ovf_r;
  logic              ge;
  logic [QB-1:0]     lim;
  logic [QB-1:0]     qs;

  assign ge  = rem_r >= ds_r;
  assign lim = QB'(1) << (COORD_W - 1);

  // A new division may start in the finishing cycle of the previous one.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE: if (start_i) state_nxt = DV_PREP;
      DV_PREP: state_nxt = DV_RUN;
      DV_RUN:  if (sh_r == '0) state_nxt = DV_FIN;
      DV_FIN:  state_nxt = start_i ? DV_PREP : DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      DV_IDLE, DV_FIN: begin
        neg_r <= num_i[AX_W-1] ^ den_i[DEN_W-1];
        nm_r  <= num_i[AX_W-1] ? AX_W'(-num_i) : AX_W'(num_i);
        dm_r  <= den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
      end
      DV_PREP: begin
        rem_r <= (DIV_W'(nm_r) << 1) + DIV_W'(dm_r);
        ds_r  <= DIV_W'(dm_r) << (QB + 1);
        q_r   <= '0;
        sh_r  <= SH_W'(QB);
        ovf_r <= 1'b0;
      end
      DV_RUN: begin
        if (sh_r == SH_W'(QB)) begin
          ovf_r <= ge;
        end else if (ge) begin
          rem_r <= rem_r - ds_r;
          q_r   <= q_r | (QB'(1) << sh_r);
        end
        ds_r <= ds_r >> 1;
        if (sh_r != '0) begin
          sh_r <= sh_r - SH_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (neg_r) begin
      qs = (ovf_r || q_r > lim) ? lim : q_r;
    end else begin
      qs = (ovf_r || q_r > lim - QB'(1)) ? lim - QB'(1) : q_r;
    end
    if (dm_r == '0) begin
      quo_o = '0;
    end else if (neg_r) begin
      quo_o = COORD_W'(QB'(0) - qs);
    end else begin
      quo_o = COORD_W'(qs);
    end
  end

  assign done_o = state_r == DV_FIN;

endmodule

// ----- src/pacpt_dp.sv -----
module pacpt_dp import pacpt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd_i,
  input  logic signed [COORD_W-1:0] in_x_i,
  input  logic signed [COORD_W-1:0] in_y_i,
  input  logic [2*COORD_W-1:0]      rd_data_i,
  input  logic                      out_tready_i,
  output sts_t                      sts_o,
  output logic                      out_tvalid_o,
  output res_t                      res_o
);

  logic signed [COORD_W-1:0] qx_r, qy_r, prev_x_r, prev_y_r, cur_x, cur_y;
  logic                      s0_v_r, s0_first_r, e1_v_r, e2_v_r, e3_v_r;
  logic signed [PROD_W-1:0]  p1_r, p2_r;
  logic signed [SUM_W-1:0]   sx1_r, sy1_r, sx2_r, sy2_r;
  logic signed [COORD_W:0]   dyq_r, dxe_r, dye_r, dxq_r;
  logic                      span1_r, dir1_r, span2_r, dir2_r;
  logic signed [CR_W-1:0]    cr_r;
  logic signed [LT_W-1:0]    lhs_r, rhs_r;
  logic signed [MOM_W-1:0]   mx_r, my_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [AX_W-1:0]    ax_r, ay_r;
  logic signed [DEN_W-1:0]   d3_r;
  logic                      par_r, below;
  logic [AREA_W-1:0]         area_r;
  logic signed [COORD_W-1:0] cx_r, cy_r;
  logic                      div_sel_r, div_done;
  logic signed [COORD_W-1:0] quo;
  logic [ACC_W-1:0]          mag, half;
  logic                      out_v_r;
  res_t                      res_r;

  assign cur_x = rd_data_i[COORD_W-1:0];
  assign cur_y = rd_data_i[2*COORD_W-1:COORD_W];
  assign below = dir2_r ? (lhs_r <= rhs_r) : (lhs_r >= rhs_r);
  assign mag   = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign half  = (mag >> 1) + ACC_W'(mag[0]);

  pacpt_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cmd_i.div_start),
    .num_i   (cmd_i.div_sel ? ay_r : ax_r),
    .den_i   (d3_r),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      e1_v_r  <= 1'b0;
      e2_v_r  <= 1'b0;
      e3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      area_r  <= '0;
      cx_r    <= '0;
      cy_r    <= '0;
    end else begin
      s0_v_r <= cmd_i.rd_valid;
      e1_v_r <= s0_v_r && !s0_first_r;
      e2_v_r <= e1_v_r;
      e3_v_r <= e2_v_r;
      if (cmd_i.res_load) begin
        out_v_r <= 1'b1;
      end else if (out_tready_i) begin
        out_v_r <= 1'b0;
      end
      if (cmd_i.clr_poly) begin
        area_r <= '0;
        cx_r   <= '0;
        cy_r   <= '0;
      end else begin
        if (cmd_i.area_upd) begin
          area_r <= (half[ACC_W-1:AREA_W] != '0) ? '1 : half[AREA_W-1:0];
        end
        if (div_done && !div_sel_r) cx_r <= quo;
        if (div_done && div_sel_r)  cy_r <= quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      qx_r <= in_x_i;
      qy_r <= in_y_i;
    end
    if (cmd_i.div_start) begin
      div_sel_r <= cmd_i.div_sel;
    end
    s0_first_r <= cmd_i.rd_first;
    if (s0_v_r) begin
      prev_x_r <= cur_x;
      prev_y_r <= cur_y;
    end
    // Stage one: cross products, coordinate sums and the differences, span and direction of the crossing test.
    p1_r    <= PROD_W'(prev_x_r) * PROD_W'(cur_y);
    p2_r    <= PROD_W'(cur_x) * PROD_W'(prev_y_r);
    sx1_r   <= SUM_W'(prev_x_r) + SUM_W'(cur_x);
    sy1_r   <= SUM_W'(prev_y_r) + SUM_W'(cur_y);
    dyq_r   <= SUM_W'(qy_r) - SUM_W'(prev_y_r);
    dxe_r   <= SUM_W'(cur_x) - SUM_W'(prev_x_r);
    dye_r   <= SUM_W'(cur_y) - SUM_W'(prev_y_r);
    dxq_r   <= SUM_W'(qx_r) - SUM_W'(prev_x_r);
    span1_r <= (qx_r >= prev_x_r && qx_r < cur_x) || (qx_r >= cur_x && qx_r < prev_x_r);
    dir1_r  <= cur_x > prev_x_r;
    // Stage two.
    cr_r    <= CR_W'(p1_r) - CR_W'(p2_r);
    lhs_r   <= LT_W'(dyq_r) * LT_W'(dxe_r);
    rhs_r   <= LT_W'(dye_r) * LT_W'(dxq_r);
    sx2_r   <= sx1_r;
    sy2_r   <= sy1_r;
    span2_r <= span1_r;
    dir2_r  <= dir1_r;
    // Stage three: first moments, the divisor and the running sums.
    mx_r    <= MOM_W'(sx2_r) * MOM_W'(cr_r);
    my_r    <= MOM_W'(sy2_r) * MOM_W'(cr_r);
    d3_r    <= DEN_W'(acc_r) + (DEN_W'(acc_r) <<< 1);
    if (cmd_i.walk_start) begin
      acc_r <= '0;
      ax_r  <= '0;
      ay_r  <= '0;
      par_r <= 1'b0;
    end else begin
      if (e2_v_r) begin
        acc_r <= acc_r + ACC_W'(cr_r);
        if (span2_r && below) par_r <= !par_r;
      end
      if (e3_v_r) begin
        ax_r <= ax_r + AX_W'(mx_r);
        ay_r <= ay_r + AX_W'(my_r);
      end
    end
    if (cmd_i.res_load) begin
      res_r.area   <= area_r;
      res_r.cx     <= cx_r;
      res_r.cy     <= cy_r;
      res_r.hit    <= cmd_i.res_inside && par_r;
      res_r.total  <= cmd_i.res_total;
      res_r.status <= cmd_i.res_status;
    end
  end

  assign sts_o.acc_zero  = acc_r == '0;
  assign sts_o.area_zero = area_r == '0;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_v_r || out_tready_i;
  assign out_tvalid_o    = out_v_r;
  assign res_o           = res_r;

endmodule

// ----- src/pacpt_ctrl.sv -----
module pacpt_ctrl import pacpt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [OP_W-1:0]   in_op_i,
  output logic              in_tready,
  input  sts_t              sts_i,
  output cmd_t              cmd_o,
  output logic              ram_we_o,
  output logic [ADDR_W-1:0] ram_waddr_o,
  output logic [ADDR_W-1:0] ram_raddr_o
);

  ctrl_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, idx_r;
  logic [DRN_W-1:0]  drn_r;
  logic [OP_W-1:0]   op_r;
  logic [STAT_W-1:0] stat_r;
  logic              inside_en_r;
  logic              accept, full, walk_go, deg;

  assign accept = in_tvalid && (state_r == S_IDLE);
  assign full   = count_r >= CNT_W'(MAX_VERTS);
  assign deg    = (count_r < CNT_W'(3)) || sts_i.area_zero;

  always_comb begin
    walk_go = 1'b0;
    unique case (in_op_i)
      OP_ADD:   walk_go = !full && count_r >= CNT_W'(2);
      OP_QUERY: walk_go = count_r >= CNT_W'(3);
      default:  walk_go = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = walk_go ? S_WALK : S_DONE;
      S_WALK:  if (idx_r == count_r) state_nxt = S_DRAIN;
      S_DRAIN: if (drn_r == DRN_W'(PIPE_LAT - 1)) state_nxt = S_AREA;
      S_AREA:  state_nxt = (op_r == OP_ADD && !sts_i.acc_zero) ? S_DIVX : S_DONE;
      S_DIVX:  if (sts_i.div_done) state_nxt = S_DIVY;
      S_DIVY:  if (sts_i.div_done) state_nxt = S_DONE;
      S_DONE:  if (sts_i.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready             = state_r == S_IDLE;
    cmd_o                 = '0;
    cmd_o.load            = accept;
    cmd_o.clr_poly        = accept && in_op_i == OP_CLEAR;
    cmd_o.walk_start      = accept && walk_go;
    cmd_o.rd_valid        = state_r == S_WALK;
    cmd_o.rd_first        = idx_r == '0;
    cmd_o.area_upd        = state_r == S_AREA && op_r == OP_ADD;
    cmd_o.div_start       = (state_r == S_AREA && op_r == OP_ADD && !sts_i.acc_zero) ||
                            (state_r == S_DIVX && sts_i.div_done);
    cmd_o.div_sel         = state_r == S_DIVX;
    cmd_o.res_load        = state_r == S_DONE && sts_i.out_free;
    cmd_o.res_status      = stat_r;
    cmd_o.res_inside      = inside_en_r;
    cmd_o.res_total       = TOTAL_W'(count_r);
    ram_we_o              = accept && in_op_i == OP_ADD && !full;
    ram_waddr_o           = count_r[ADDR_W-1:0];
    ram_raddr_o           = (idx_r == count_r) ? '0 : idx_r[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      drn_r       <= '0;
      op_r        <= '0;
      stat_r      <= ST_OK;
      inside_en_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          idx_r <= '0;
          drn_r <= '0;
          if (accept) begin
            op_r        <= in_op_i;
            inside_en_r <= in_op_i == OP_QUERY && count_r >= CNT_W'(3);
            unique case (in_op_i)
              OP_CLEAR: begin
                count_r <= '0;
                stat_r  <= ST_DEG;
              end
              OP_ADD: begin
                if (full) begin
                  stat_r <= ST_FULL;
                end else begin
                  count_r <= count_r + CNT_W'(1);
                  stat_r  <= ST_DEG;
                end
              end
              default: stat_r <= deg ? ST_DEG : ST_OK;
            endcase
          end
        end
        S_WALK:  idx_r <= idx_r + CNT_W'(1);
        S_DRAIN: drn_r <= drn_r + DRN_W'(1);
        S_AREA:  if (op_r == OP_ADD) stat_r <= sts_i.acc_zero ? ST_DEG : ST_OK;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/polygon_area_centroid_point_test_unit.sv -----
// Polygon store with shoelace area, centroid and even-odd point test.
// Requests enter on the in_ stream: in_tuser carries the opcode (clear, add a
// vertex, query a point) and in_tdata the Q11.4 coordinates. Every request
// produces exactly one result on the out_ stream, with the area magnitude,
// the centroid, the query answer, the vertex count in out_tdata and the
// status code in out_tuser.
// A request is taken only while the controller is idle. Clear, an add that
// leaves fewer than three vertices, an add to a full store and a query on
// fewer than three vertices go from idle straight to the done state, which
// loads the result register. A query walks every stored edge once. An
// add that leaves three or more vertices walks the edges and then runs the
// shared bit-serial divider twice for the centroid, unless the area is zero.
// The edge walk reads one vertex per cycle from the store, and there is
// one request in work at a time.
// The result sits in an output register, so the next request is accepted
// while an earlier result still waits for out_tready; a stalled receiver
// only holds the following result back. Synchronous reset empties the
// polygon and zeroes area and centroid; the vertex store is not cleared.
module polygon_area_centroid_point_test_unit import pacpt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // coord_x [15:0], coord_y [31:16]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // opcode [1:0]
  input  logic [OP_W-1:0]        in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // poly_area [35:0], center_x [51:36], center_y [67:52], inside_res [68],
  // vertex_total [75:69], zero fill [79:76]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status [1:0]
  output logic [STAT_W-1:0]      out_tuser
);

  cmd_t                  cmd;
  sts_t                  sts;
  res_t                  res;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [2*COORD_W-1:0]  ram_rdata;

  // The controller sequences each request; the datapath holds the edge
  // pipeline, the sums, the divider and the output register.
  pacpt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_op_i     (in_tuser),
    .in_tready   (in_tready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_raddr_o (ram_raddr)
  );

  // Each vertex is stored as one word, y in the upper half.
  pacpt_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_VERTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pacpt_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_i        (cmd),
    .in_x_i       (in_tdata[COORD_W-1:0]),
    .in_y_i       (in_tdata[2*COORD_W-1:COORD_W]),
    .rd_data_i    (ram_rdata),
    .out_tready_i (out_tready),
    .sts_o        (sts),
    .out_tvalid_o (out_tvalid),
    .res_o        (res)
  );

  assign out_tdata = {{(OUT_TDATA_W - RES_BITS){1'b0}}, res.total, res.hit,
                      res.cy, res.cx, res.area};
  assign out_tuser = res.status;

  // The vertex count never passes the store depth.
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[75:69] <= TOTAL_W'(MAX_VERTS))
    else $error("vertex count above store depth");

  // A dropped vertex is reported only when the store is full.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> out_tdata[75:69] == TOTAL_W'(MAX_VERTS))
    else $error("full status with free store entries");

  // An inside answer needs a polygon of at least three vertices.
  a_inside_poly: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[68] |-> out_tdata[75:69] >= TOTAL_W'(3))
    else $error("inside answer without a polygon");

  // One request at a time: after an acceptance the input is closed.
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request accepted while busy");

endmodule
